/* rtl/core/jsd_pkg.sv */
package jsd_pkg;

  // Input word: one file byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  // Result word: frame byte, header info or end-of-file status
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        frame_first;
    logic        frame_last;
    logic [7:0]  frame_index;
    logic [7:0]  frame_limit;
    logic [15:0] speed;
    logic [7:0]  tile_rows;
    logic [7:0]  tile_cols;
    logic [7:0]  frames_found;
    logic        open_dropped;
    logic        status;
  } out_t;

  // Results one byte can cause: up to two frame bytes plus a status word
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]                count;
    out_t [MaxResults-1:0]     item;
  } push_t;

  // Result kinds
  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_EOF    = 2'd2;

  // Markers and gap pattern
  localparam logic [7:0] MARK_FF  = 8'hFF;
  localparam logic [7:0] MARK_SOI = 8'hD8;
  localparam logic [7:0] MARK_EOI = 8'hD9;
  localparam logic [7:0] GAP_HEAD = 8'h02;
  localparam logic [7:0] GAP_FILL = 8'h00;

  localparam logic [15:0] DEFAULT_SPEED = 16'd50;
  localparam logic [3:0]  HEADER_LAST   = 4'd4;

  // Build a frame byte word
  function automatic out_t frame_word(logic [7:0] b, logic first, logic last,
                                      logic [7:0] idx);
    out_t w;
    w             = '0;
    w.kind        = KIND_FRAME;
    w.out_byte    = b;
    w.frame_first = first;
    w.frame_last  = last;
    w.frame_index = idx;
    return w;
  endfunction

endpackage

/* rtl/core/jsd_parse.sv */
module jsd_parse #(
  parameter int unsigned RESERVED_BYTES = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  jsd_pkg::in_t  word,
  output jsd_pkg::push_t push
);
  import jsd_pkg::*;

  // Scan modes
  localparam logic [2:0] M_HEADER   = 3'd0;
  localparam logic [2:0] M_RESERVED = 3'd1;
  localparam logic [2:0] M_SCAN     = 3'd2;
  localparam logic [2:0] M_FRAME    = 3'd3;
  localparam logic [2:0] M_GAP      = 3'd4;
  localparam logic [2:0] M_SKIP     = 3'd5;
  localparam logic [2:0] M_DONE     = 3'd6;

  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  limit_reg, limit_reg_next;
  logic [15:0] speed_reg, speed_reg_next;
  logic [7:0]  rows_reg, rows_reg_next;
  logic [7:0]  cols_reg, cols_reg_next;
  logic [2:0]  scan_mode, scan_mode_next;
  logic        prev_was_ff, prev_was_ff_next;
  logic [1:0]  gap_count, gap_count_next;
  logic [7:0]  frame_count, frame_count_next;
  logic        payload_seen, payload_seen_next;

  // Next state and results for the byte on the input
  always_comb begin
    logic [7:0] b;
    logic [3:0] pos_inc;
    logic [1:0] gap_inc;
    logic [1:0] nbody;
    logic       bad;
    out_t       status_word;

    b       = word.in_byte;
    pos_inc = byte_position + 4'd1;
    gap_inc = gap_count + 2'd1;
    nbody   = 2'd0;

    byte_position_next = byte_position;
    limit_reg_next     = limit_reg;
    speed_reg_next     = speed_reg;
    rows_reg_next      = rows_reg;
    cols_reg_next      = cols_reg;
    scan_mode_next     = scan_mode;
    prev_was_ff_next   = prev_was_ff;
    gap_count_next     = gap_count;
    frame_count_next   = frame_count;
    payload_seen_next  = payload_seen;
    push               = '0;

    case (scan_mode)
      M_HEADER: begin
        case (byte_position)
          4'd0:    limit_reg_next = b;
          4'd1:    speed_reg_next = {b, speed_reg[7:0]};
          4'd2:    speed_reg_next = {speed_reg[15:8], b};
          4'd3:    rows_reg_next  = (b != 8'd0) ? b : 8'd1;
          default: cols_reg_next  = (b != 8'd0) ? b : 8'd1;
        endcase
        if (byte_position >= HEADER_LAST) begin
          push.item[0]             = '0;
          push.item[0].kind        = KIND_HEADER;
          push.item[0].frame_limit = limit_reg_next;
          push.item[0].speed       = (speed_reg_next != 16'd0) ? speed_reg_next
                                                               : DEFAULT_SPEED;
          push.item[0].tile_rows   = rows_reg_next;
          push.item[0].tile_cols   = cols_reg_next;
          nbody                    = 2'd1;
          byte_position_next       = 4'd0;
          scan_mode_next           = (RESERVED_BYTES > 0) ? M_RESERVED : M_SCAN;
        end else begin
          byte_position_next = pos_inc;
        end
      end
      M_RESERVED: begin
        byte_position_next = pos_inc;
        if (pos_inc >= 4'(RESERVED_BYTES)) begin
          byte_position_next = 4'd0;
          scan_mode_next     = M_SCAN;
        end
      end
      M_SCAN: begin
        payload_seen_next = 1'b1;
        if (prev_was_ff && b == MARK_SOI) begin
          push.item[0]     = frame_word(MARK_FF, 1'b1, 1'b0, frame_count);
          push.item[1]     = frame_word(b, 1'b0, 1'b0, frame_count);
          nbody            = 2'd2;
          scan_mode_next   = M_FRAME;
          prev_was_ff_next = 1'b0;
        end else begin
          prev_was_ff_next = (b == MARK_FF);
        end
      end
      M_FRAME: begin
        payload_seen_next = 1'b1;
        nbody             = 2'd1;
        if (prev_was_ff && b == MARK_EOI) begin
          push.item[0]     = frame_word(b, 1'b0, 1'b1, frame_count);
          prev_was_ff_next = 1'b0;
          if (frame_count != 8'hFF) frame_count_next = frame_count + 8'd1;
          if (limit_reg != 8'd0 && frame_count_next >= limit_reg) begin
            scan_mode_next = M_DONE;
          end else begin
            scan_mode_next = M_GAP;
            gap_count_next = 2'd0;
          end
        end else begin
          push.item[0]     = frame_word(b, 1'b0, 1'b0, frame_count);
          prev_was_ff_next = (b == MARK_FF);
        end
      end
      M_GAP: begin
        payload_seen_next = 1'b1;
        if (b == ((gap_count == 2'd0) ? GAP_HEAD : GAP_FILL)) begin
          gap_count_next = gap_inc;
          if (gap_inc == 2'd3) begin
            gap_count_next = 2'd0;
            scan_mode_next = M_SKIP;
          end
        end else begin
          // pattern broken: rescan this byte with no pending 0xFF
          gap_count_next   = 2'd0;
          scan_mode_next   = M_SCAN;
          prev_was_ff_next = (b == MARK_FF);
        end
      end
      M_SKIP: begin
        payload_seen_next = 1'b1;
        gap_count_next    = gap_inc;
        if (gap_inc >= 2'd2) begin
          gap_count_next   = 2'd0;
          scan_mode_next   = M_SCAN;
          prev_was_ff_next = 1'b0;
        end
      end
      default: begin
        payload_seen_next = 1'b1;
      end
    endcase

    // End-of-file status follows the byte's own results
    bad = (scan_mode_next == M_HEADER) || !payload_seen_next ||
          (frame_count_next == 8'd0);
    status_word              = '0;
    status_word.kind         = KIND_EOF;
    status_word.frames_found = frame_count_next;
    status_word.open_dropped = (scan_mode_next == M_FRAME);
    status_word.status       = bad;

    push.count = nbody;
    if (word.in_last) begin
      case (nbody)
        2'd0:    push.item[0] = status_word;
        2'd1:    push.item[1] = status_word;
        default: push.item[2] = status_word;
      endcase
      push.count = nbody + 2'd1;

      // back to the reset state for the next file
      byte_position_next = 4'd0;
      limit_reg_next     = 8'd0;
      speed_reg_next     = 16'd0;
      rows_reg_next      = 8'd1;
      cols_reg_next      = 8'd1;
      scan_mode_next     = M_HEADER;
      prev_was_ff_next   = 1'b0;
      gap_count_next     = 2'd0;
      frame_count_next   = 8'd0;
      payload_seen_next  = 1'b0;
    end

    if (!fire) push.count = 2'd0;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 4'd0;
      limit_reg     <= 8'd0;
      speed_reg     <= 16'd0;
      rows_reg      <= 8'd1;
      cols_reg      <= 8'd1;
      scan_mode     <= M_HEADER;
      prev_was_ff   <= 1'b0;
      gap_count     <= 2'd0;
      frame_count   <= 8'd0;
      payload_seen  <= 1'b0;
    end else if (fire) begin
      byte_position <= byte_position_next;
      limit_reg     <= limit_reg_next;
      speed_reg     <= speed_reg_next;
      rows_reg      <= rows_reg_next;
      cols_reg      <= cols_reg_next;
      scan_mode     <= scan_mode_next;
      prev_was_ff   <= prev_was_ff_next;
      gap_count     <= gap_count_next;
      frame_count   <= frame_count_next;
      payload_seen  <= payload_seen_next;
    end
  end

endmodule

/* rtl/core/jsd_queue.sv */
module jsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  jsd_pkg::push_t push,
  output logic           room,
  output logic           valid,
  input  logic           ready,
  output jsd_pkg::out_t  data
);
  import jsd_pkg::*;

  out_t       entry [0:3];
  logic [1:0] head;
  logic [2:0] fill;
  logic [1:0] tail;
  logic       pop;

  // Room for a full burst of results from one byte
  assign room  = (fill <= 3'd1);
  assign valid = (fill != 3'd0);
  assign data  = entry[head];
  assign pop   = valid && ready;
  assign tail  = head + fill[1:0];

  // Result storage, up to three words written per cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < push.count) entry[tail + 2'(i)] <= push.item[i];
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (pop) head <= head + 2'd1;
      fill <= fill - {2'd0, pop} + {1'b0, push.count};
    end
  end

endmodule

/* rtl/core/jpeg_sequence_deframer_unit.sv */
// With the queue empty, the first result of an accepted byte is on res_data the
// next cycle.
// Throughput: one byte per cycle while at most one result word is queued; a
// byte causes up to three result words, drained one per cycle while res_ready is high.
// Reset: synchronous rst returns the parser to header mode and empties the queue.
// After the last byte of a file the parser returns to header mode on its own.
module jpeg_sequence_deframer_unit #(
  parameter int unsigned RESERVED_BYTES = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_ready,
  input  jsd_pkg::in_t  byte_data,
  output logic          res_valid,
  input  logic          res_ready,
  output jsd_pkg::out_t res_data
);
  import jsd_pkg::*;

  push_t push;
  logic  room;
  logic  fire;

  assign byte_ready = room;
  assign fire       = byte_valid && room;

  // Marker parser
  jsd_parse #(
    .RESERVED_BYTES(RESERVED_BYTES)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (byte_data),
    .push (push)
  );

  // Result queue
  jsd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .valid (res_valid),
    .ready (res_ready),
    .data  (res_data)
  );

endmodule

/* dv/jsd_checker.sv */
module jsd_checker #(
  parameter int unsigned RESERVED_BYTES = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  input  logic          byte_ready,
  input  jsd_pkg::in_t  byte_data,
  input  logic          res_valid,
  input  logic          res_ready,
  input  jsd_pkg::out_t res_data,
  output int            mismatch_count,
  output int            words_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import jsd_pkg::*;

  typedef enum logic [2:0] {
    MODE_HEADER,
    MODE_RESERVED,
    MODE_SCAN,
    MODE_FRAME,
    MODE_GAP,
    MODE_SKIP,
    MODE_DONE
  } parse_mode_e;

  // Parser shadow state
  parse_mode_e mode;
  logic [3:0]  pos;
  logic [7:0]  limit_q;
  logic [15:0] speed_q;
  logic [7:0]  rows_q;
  logic [7:0]  cols_q;
  logic        ff_seen;
  logic [2:0]  gap_cnt;
  logic [7:0]  frames;
  logic        payload;
  logic [7:0]  cur_idx;

  out_t owed_words[$];
  int   fails  = 0;
  int   owed_n = 0;

  assign mismatch_count = fails;
  assign words_owed     = owed_n;

  task automatic reset_parser();
    mode    = MODE_HEADER;
    pos     = '0;
    limit_q = '0;
    speed_q = '0;
    rows_q  = 8'd1;
    cols_q  = 8'd1;
    ff_seen = 1'b0;
    gap_cnt = '0;
    frames  = '0;
    payload = 1'b0;
    cur_idx = '0;
  endtask

  task automatic owe_frame_word(logic [7:0] b, logic first, logic last);
    out_t w;
    w             = '0;
    w.kind        = KIND_FRAME;
    w.out_byte    = b;
    w.frame_first = first;
    w.frame_last  = last;
    w.frame_index = cur_idx;
    owed_words.push_back(w);
  endtask

  // Hunt for FF D8 outside a frame
  task automatic hunt_soi(logic [7:0] b);
    if (ff_seen && b == MARK_SOI) begin
      cur_idx = frames;
      owe_frame_word(MARK_FF, 1'b1, 1'b0);
      owe_frame_word(b, 1'b0, 1'b0);
      mode    = MODE_FRAME;
      ff_seen = 1'b0;
    end else begin
      ff_seen = (b == MARK_FF);
    end
  endtask

  // Predict the words one accepted byte causes
  task automatic parse_byte(in_t in_w);
    logic [7:0] b;
    out_t       w;
    b = in_w.in_byte;
    case (mode)
      MODE_HEADER: begin
        case (pos)
          4'd0: limit_q = b;
          4'd1: speed_q[15:8] = b;
          4'd2: speed_q[7:0] = b;
          4'd3: rows_q = (b != 0) ? b : 8'd1;
          default: cols_q = (b != 0) ? b : 8'd1;
        endcase
        if (pos >= HEADER_LAST) begin
          w             = '0;
          w.kind        = KIND_HEADER;
          w.frame_limit = limit_q;
          w.speed       = (speed_q != 0) ? speed_q : DEFAULT_SPEED;
          w.tile_rows   = rows_q;
          w.tile_cols   = cols_q;
          owed_words.push_back(w);
          pos  = '0;
          mode = (RESERVED_BYTES > 0) ? MODE_RESERVED : MODE_SCAN;
        end else begin
          pos = pos + 4'd1;
        end
      end
      MODE_RESERVED: begin
        pos = pos + 4'd1;
        if (pos >= RESERVED_BYTES) begin
          pos  = '0;
          mode = MODE_SCAN;
        end
      end
      MODE_SCAN: begin
        payload = 1'b1;
        hunt_soi(b);
      end
      MODE_FRAME: begin
        payload = 1'b1;
        if (ff_seen && b == MARK_EOI) begin
          owe_frame_word(b, 1'b0, 1'b1);
          ff_seen = 1'b0;
          if (frames != 8'hFF) frames = frames + 8'd1;
          if (limit_q != 0 && frames >= limit_q) begin
            mode = MODE_DONE;
          end else begin
            mode    = MODE_GAP;
            gap_cnt = '0;
          end
        end else begin
          owe_frame_word(b, 1'b0, 1'b0);
          ff_seen = (b == MARK_FF);
        end
      end
      MODE_GAP: begin
        payload = 1'b1;
        if (b == ((gap_cnt == 0) ? GAP_HEAD : GAP_FILL)) begin
          gap_cnt = gap_cnt + 3'd1;
          if (gap_cnt >= 3) begin
            gap_cnt = '0;
            mode    = MODE_SKIP;
          end
        end else begin
          // broken gap: rescan this byte with no pending FF
          gap_cnt = '0;
          mode    = MODE_SCAN;
          ff_seen = 1'b0;
          hunt_soi(b);
        end
      end
      MODE_SKIP: begin
        payload = 1'b1;
        gap_cnt = gap_cnt + 3'd1;
        if (gap_cnt >= 2) begin
          gap_cnt = '0;
          mode    = MODE_SCAN;
          ff_seen = 1'b0;
        end
      end
      default: payload = 1'b1;
    endcase

    // End-of-file status, then back to header mode
    if (in_w.in_last) begin
      w              = '0;
      w.kind         = KIND_EOF;
      w.frames_found = frames;
      w.open_dropped = (mode == MODE_FRAME);
      w.status       = (mode == MODE_HEADER) || !payload || (frames == 0);
      owed_words.push_back(w);
      reset_parser();
    end
  endtask

  task automatic compare_word(out_t exp_w, out_t act_w);
    if (act_w.kind !== exp_w.kind) begin
      $error("kind: expected %0d, got %0d", exp_w.kind, act_w.kind);
      fails++;
    end
    if (act_w.out_byte !== exp_w.out_byte) begin
      $error("out_byte: expected %0h, got %0h", exp_w.out_byte, act_w.out_byte);
      fails++;
    end
    if (act_w.frame_first !== exp_w.frame_first) begin
      $error("frame_first: expected %0d, got %0d", exp_w.frame_first, act_w.frame_first);
      fails++;
    end
    if (act_w.frame_last !== exp_w.frame_last) begin
      $error("frame_last: expected %0d, got %0d", exp_w.frame_last, act_w.frame_last);
      fails++;
    end
    if (act_w.frame_index !== exp_w.frame_index) begin
      $error("frame_index: expected %0d, got %0d", exp_w.frame_index, act_w.frame_index);
      fails++;
    end
    if (act_w.frame_limit !== exp_w.frame_limit) begin
      $error("frame_limit: expected %0d, got %0d", exp_w.frame_limit, act_w.frame_limit);
      fails++;
    end
    if (act_w.speed !== exp_w.speed) begin
      $error("speed: expected %0d, got %0d", exp_w.speed, act_w.speed);
      fails++;
    end
    if (act_w.tile_rows !== exp_w.tile_rows) begin
      $error("tile_rows: expected %0d, got %0d", exp_w.tile_rows, act_w.tile_rows);
      fails++;
    end
    if (act_w.tile_cols !== exp_w.tile_cols) begin
      $error("tile_cols: expected %0d, got %0d", exp_w.tile_cols, act_w.tile_cols);
      fails++;
    end
    if (act_w.frames_found !== exp_w.frames_found) begin
      $error("frames_found: expected %0d, got %0d", exp_w.frames_found,
             act_w.frames_found);
      fails++;
    end
    if (act_w.open_dropped !== exp_w.open_dropped) begin
      $error("open_dropped: expected %0d, got %0d", exp_w.open_dropped,
             act_w.open_dropped);
      fails++;
    end
    if (act_w.status !== exp_w.status) begin
      $error("status: expected %0d, got %0d", exp_w.status, act_w.status);
      fails++;
    end
  endtask

  // Watch both channels; each accepted result word is checked against the oldest owed word
  always @(posedge clk) begin
    out_t exp_w;
    if (rst) begin
      reset_parser();
      owed_words.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (owed_words.size() == 0) begin
          $error("result word with nothing owed: kind %0d", res_data.kind);
          fails++;
        end else begin
          exp_w = owed_words.pop_front();
          compare_word(exp_w, res_data);
        end
      end
      if (byte_valid && byte_ready) parse_byte(byte_data);
    end
    owed_n <= owed_words.size();
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jsd_pkg::*;

  localparam int unsigned RsvBytes  = 9;
  localparam int          IdleLimit = 2000;

  logic clk        = 1'b0;
  logic rst        = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_ready;
  in_t  byte_data  = '0;
  logic res_valid;
  logic res_ready  = 1'b0;
  out_t res_data;

  logic [8:0] stall_phase = '0;
  int         mismatch_count;
  int         words_owed;
  int         burst_left = 0;
  logic [7:0] file_q[$];

  jpeg_sequence_deframer_unit #(.RESERVED_BYTES(RsvBytes)) u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  jsd_checker #(.RESERVED_BYTES(RsvBytes)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .byte_data      (byte_data),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .mismatch_count (mismatch_count),
    .words_owed     (words_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: always ready, coin flip, a quarter of cycles stalled, long stalls
  always @(negedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: res_ready <= 1'b1;
      2'd1: res_ready <= ($urandom_range(0, 1) == 1);
      2'd2: res_ready <= (stall_phase[1:0] != 2'd0);
      default: res_ready <= (stall_phase[3:0] < 4'd3);
    endcase
  end

  // Watchdog: cycles with no word moving on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk);
      if ((byte_valid && byte_ready) || (res_valid && res_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Marker-heavy byte mix
  function automatic logic [7:0] noisy_byte();
    case ($urandom_range(0, 7))
      0: return MARK_FF;
      1: return MARK_SOI;
      2: return MARK_EOI;
      3: return GAP_HEAD;
      4: return GAP_FILL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: bursts of words with idle gaps between them
  task automatic send_byte(in_t w);
    if (burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
    end
    byte_valid <= 1'b1;
    byte_data  <= w;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_file();
    in_t w;
    foreach (file_q[i]) begin
      w.in_byte = file_q[i];
      w.in_last = (i == file_q.size() - 1);
      send_byte(w);
    end
    file_q.delete();
  endtask

  // Hold the sender until every owed word has come out
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
  endtask

  task automatic put_header(logic [7:0] lim, logic [15:0] spd, logic [7:0] rows,
                            logic [7:0] cols);
    file_q.push_back(lim);
    file_q.push_back(spd[15:8]);
    file_q.push_back(spd[7:0]);
    file_q.push_back(rows);
    file_q.push_back(cols);
    repeat (RsvBytes) file_q.push_back(noisy_byte());
  endtask

  // Well-formed frame; body never closes it early
  task automatic put_frame(int body_len);
    logic [7:0] b;
    file_q.push_back(MARK_FF);
    file_q.push_back(MARK_SOI);
    repeat (body_len) begin
      b = noisy_byte();
      if (file_q[$] == MARK_FF && b == MARK_EOI) b = GAP_FILL;
      file_q.push_back(b);
    end
    file_q.push_back(MARK_FF);
    file_q.push_back(MARK_EOI);
  endtask

  // 0 full gap, 1 gap cut short, 2 none, 3 junk
  task automatic put_gap(int variant);
    case (variant)
      0: begin
        file_q.push_back(GAP_HEAD);
        file_q.push_back(GAP_FILL);
        file_q.push_back(GAP_FILL);
        file_q.push_back(noisy_byte());
        file_q.push_back(noisy_byte());
      end
      1: begin
        file_q.push_back(GAP_HEAD);
        if ($urandom_range(0, 1) == 1) file_q.push_back(GAP_FILL);
        file_q.push_back(8'($urandom_range(1, 255)));
      end
      2: ;
      default: repeat ($urandom_range(1, 3)) file_q.push_back(noisy_byte());
    endcase
  endtask

  initial begin : stimulus
    int         random_bytes;
    logic [7:0] lim;
    logic [15:0] spd;
    logic [7:0] rows;
    logic [7:0] cols;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Header cut short
    file_q.push_back(8'h03);
    file_q.push_back(8'h00);
    file_q.push_back(8'h10);
    send_file();
    wait_drained();

    // One-byte file
    file_q.push_back(8'hFF);
    send_file();

    // Zero header fields, file ends inside the reserved bytes
    put_header(8'h00, 16'h0000, 8'h00, 8'h00);
    repeat (RsvBytes - 2) void'(file_q.pop_back());
    send_file();

    // Field maxima, empty payload
    put_header(8'hFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_file();

    // Limit of two: junk, frames with full and broken gaps, third frame ignored
    put_header(8'h02, 16'h0100, 8'h04, 8'h03);
    file_q.push_back(MARK_FF);
    file_q.push_back(8'h11);
    put_frame(3);
    put_gap(0);
    put_frame(0);
    put_gap(1);
    put_frame(2);
    send_file();
    wait_drained();

    // Gap broken by a new SOI, frame left open at the end
    put_header(8'h00, 16'h0001, 8'h01, 8'h02);
    put_frame(1);
    file_q.push_back(GAP_HEAD);
    file_q.push_back(GAP_FILL);
    file_q.push_back(MARK_FF);
    file_q.push_back(MARK_SOI);
    file_q.push_back(8'hAA);
    file_q.push_back(8'h55);
    send_file();

    // Back-to-back minimal frames
    put_header(8'h00, 16'h0032, 8'h02, 8'h02);
    repeat (6) put_frame(0);
    send_file();
    wait_drained();

    // Random files: mostly well-formed with random content, some noise
    random_bytes = 0;
    while (random_bytes < 180) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 20)) file_q.push_back(noisy_byte());
      end else begin
        case ($urandom_range(0, 2))
          0: lim = 8'h00;
          1: lim = 8'($urandom_range(1, 3));
          default: lim = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 3))
          0: spd = 16'h0000;
          1: spd = 16'hFFFF;
          default: spd = 16'($urandom_range(0, 65535));
        endcase
        rows = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        cols = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        put_header(lim, spd, rows, cols);
        repeat ($urandom_range(0, 4)) begin
          repeat ($urandom_range(0, 3)) file_q.push_back(noisy_byte());
          put_frame($urandom_range(0, 10));
          put_gap($urandom_range(0, 3));
        end
        case ($urandom_range(0, 3))
          // unterminated frame
          1: begin
            file_q.push_back(MARK_FF);
            file_q.push_back(MARK_SOI);
            repeat ($urandom_range(0, 4)) file_q.push_back(noisy_byte());
          end
          2: repeat ($urandom_range(1, 4)) file_q.push_back(noisy_byte());
          default: ;
        endcase
      end
      random_bytes += file_q.size();
      send_file();
      if ($urandom_range(0, 5) == 0) wait_drained();
    end

    // Drain, then let the pipeline settle
    byte_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
